/* design/twvs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twvs_pkg
// Shared widths, types and state codes of the time window volume sum block.
// ----------------------------------------------------------------------------
package twvs_pkg;

	localparam int TIME_W = 63;
	localparam int VOL_W  = 32;
	localparam int WIN_W  = 40;
	localparam int SUM_W  = 38;
	localparam int HELD_W = 7;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 40'd3000000000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DROP,
		ST_INSERT
	} state_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] total;
		logic [HELD_W-1:0]       held;
		logic                    ovf;
	} result_t;

endpackage

/* design/twvs_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twvs_ring
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module twvs_ring #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 95
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* design/twvs_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twvs_seq
// Sequencer and datapath: ages out old entries one per cycle through a single
// shared total adder, drops the oldest entry when full, then appends.
// ----------------------------------------------------------------------------
module twvs_seq import twvs_pkg::*; #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [WIN_W-1:0]                window,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [TIME_W-1:0]               event_time_ns,
	input  logic signed [VOL_W-1:0]         volume,
	output logic                            res_valid,
	input  logic                            res_take,
	output result_t                         res,
	output logic                            wr_en,
	output logic [$clog2(WINDOW_DEPTH)-1:0] wr_addr,
	output logic [TIME_W+VOL_W-1:0]         wr_data,
	output logic [$clog2(WINDOW_DEPTH)-1:0] rd_addr,
	input  logic [TIME_W+VOL_W-1:0]         rd_data
);

	localparam int IW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(WINDOW_DEPTH);
	localparam logic [IW:0]   DEPTH_EXT = (IW+1)'(WINDOW_DEPTH);
	localparam logic [IW-1:0] LAST_IDX  = IW'(WINDOW_DEPTH - 1);

	state_t state_q, state_d;

	logic [IW-1:0]           oldest_q;
	logic [CW-1:0]           count_q;
	logic signed [SUM_W-1:0] total_q;
	logic                    ovf_q;
	logic [TIME_W-1:0]       time_q;
	logic signed [VOL_W-1:0] vol_q;

	logic                    accept;
	logic [TIME_W-1:0]       old_time;
	logic signed [VOL_W-1:0] old_vol;
	logic [TIME_W-1:0]       age;
	logic                    expired;
	logic [IW-1:0]           oldest_next;
	logic [IW:0]             slot_sum;
	logic [IW-1:0]           slot;
	logic signed [SUM_W-1:0] add_op;
	logic signed [SUM_W-1:0] total_d;
	logic [CW-1:0]           count_inc;

	assign accept   = in_valid && !in_stall;
	assign old_time = rd_data[TIME_W+VOL_W-1:VOL_W];
	assign old_vol  = rd_data[VOL_W-1:0];

	// a timestamp behind the entry never expires it, whatever the wrapped age
	assign age     = time_q - old_time;
	assign expired = (time_q > old_time) && (age > TIME_W'(window));

	assign oldest_next = (oldest_q == LAST_IDX) ? '0 : oldest_q + 1'b1;

	assign slot_sum = {1'b0, oldest_q} + (IW+1)'(count_q);
	assign slot     = (slot_sum >= DEPTH_EXT) ? IW'(slot_sum - DEPTH_EXT) : slot_sum[IW-1:0];

	// shared total adder: subtract a leaving volume, or add the new one
	assign add_op    = (state_q == ST_INSERT) ? SUM_W'(vol_q) : -SUM_W'(old_vol);
	assign total_d   = total_q + add_op;
	assign count_inc = count_q + 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (count_q == '0) ? ST_INSERT : ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (expired) begin
					if (count_q == CW'(1)) begin
						state_d = ST_INSERT;
					end
				end else if (count_q == FULL_CNT) begin
					state_d = ST_DROP;
				end else begin
					state_d = ST_INSERT;
				end
			end
			ST_DROP: begin
				state_d = ST_INSERT;
			end
			ST_INSERT: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		res_valid = (state_q == ST_INSERT);
		wr_en     = (state_q == ST_INSERT) && res_take;
		// keep the oldest entry in the read register, advancing on an eviction
		rd_addr   = (state_q == ST_CHECK && expired) ? oldest_next : oldest_q;
	end

	assign wr_addr   = slot;
	assign wr_data   = {time_q, vol_q};
	assign res.total = total_d;
	assign res.held  = HELD_W'(count_inc);
	assign res.ovf   = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			oldest_q <= '0;
			count_q  <= '0;
			total_q  <= '0;
			ovf_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					ovf_q <= 1'b0;
				end
				ST_CHECK: begin
					if (expired) begin
						total_q  <= total_d;
						oldest_q <= oldest_next;
						count_q  <= count_q - 1'b1;
					end
				end
				ST_DROP: begin
					total_q  <= total_d;
					oldest_q <= oldest_next;
					count_q  <= count_q - 1'b1;
					ovf_q    <= 1'b1;
				end
				ST_INSERT: begin
					if (res_take) begin
						total_q <= total_d;
						count_q <= count_inc;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			time_q <= event_time_ns;
			vol_q  <= volume;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("entry count above ring depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INSERT |-> count_q < FULL_CNT)
		else $error("append with no free slot");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> count_q != '0)
		else $error("age check on empty ring");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DROP |=> state_q == ST_INSERT && ovf_q)
		else $error("overflow drop not followed by append");

endmodule

/* design/time_window_volume_sum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_window_volume_sum
// Running sum of signed volumes over a sliding time window of events.
// ----------------------------------------------------------------------------
// Each accepted word (timestamp, volume) first retires held entries, oldest
// first and one entry per cycle, while they are older than window_ns, and
// stops at the first entry that is not; it then drops the oldest entry if the
// ring is still full, appends the new entry and returns the total, the count
// held and the overflow flag. The retire rate is set by the single registered
// ring read port and the single total adder, both stepped once per cycle. The
// input stalls while an item is in work and until its result is taken into
// the output register, where the finished result waits for the receiver.
module time_window_volume_sum import twvs_pkg::*; #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [WIN_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [TIME_W-1:0]        event_time_ns,
	input  logic signed [VOL_W-1:0]  volume,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [SUM_W-1:0]  window_total,
	output logic [HELD_W-1:0]        entries_held,
	output logic                     overflow
);

	localparam int IW = $clog2(WINDOW_DEPTH);

	logic [WIN_W-1:0]        window_q;
	logic                    res_valid;
	logic                    res_take;
	result_t                 res;
	logic                    out_valid_q;
	result_t                 out_q;
	logic                    wr_en;
	logic [IW-1:0]           wr_addr;
	logic [TIME_W+VOL_W-1:0] wr_data;
	logic [IW-1:0]           rd_addr;
	logic [TIME_W+VOL_W-1:0] rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_data;
		end
	end

	twvs_ring #(
		.DEPTH  (WINDOW_DEPTH),
		.DATA_W (TIME_W + VOL_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	twvs_seq #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.window        (window_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.event_time_ns (event_time_ns),
		.volume        (volume),
		.res_valid     (res_valid),
		.res_take      (res_take),
		.res           (res),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data)
	);

	// output word register, loads when empty or being drained
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign window_total = out_q.total;
	assign entries_held = out_q.held;
	assign overflow     = out_q.ovf;

endmodule

/* test/time_window_volume_sum_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_window_volume_sum_check
// Watches the config, event and result channels of the window sum block.
// Every accepted event word updates a local copy of the window ring and the
// running total, and the predicted result waits in a queue. Each accepted
// result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module time_window_volume_sum_check import twvs_pkg::*; #(
	parameter int WINDOW_DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [WIN_W-1:0]         cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [TIME_W-1:0]        event_time_ns,
	input  logic signed [VOL_W-1:0]  volume,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [SUM_W-1:0]  window_total,
	input  logic [HELD_W-1:0]        entries_held,
	input  logic                     overflow,
	output int                       mismatches,
	output int                       outstanding
);

	logic [TIME_W-1:0]       ring_time [WINDOW_DEPTH];
	logic signed [VOL_W-1:0] ring_vol [WINDOW_DEPTH];
	int                      oldest_slot;
	int                      held;
	logic signed [SUM_W-1:0] total;
	logic [WIN_W-1:0]        win;
	result_t                 predicted_results [$];
	result_t                 want;

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	function automatic logic signed [SUM_W-1:0] widen_vol(input logic signed [VOL_W-1:0] v);
		return {{(SUM_W-VOL_W){v[VOL_W-1]}}, v};
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint exp_val);
		$display("%0t mismatch: %s got %0d wanted %0d", $realtime, what, got, exp_val);
		mismatches++;
	endtask

	task automatic retire_oldest();
		total = total - widen_vol(ring_vol[oldest_slot]);
		oldest_slot = (oldest_slot + 1 >= WINDOW_DEPTH) ? 0 : oldest_slot + 1;
		held--;
	endtask

	// evict aged entries, make room, append, then queue the predicted word
	task automatic apply_event(input logic [TIME_W-1:0] t, input logic signed [VOL_W-1:0] v);
		logic [TIME_W-1:0] age;
		logic              dropped;
		int                slot;
		result_t           res;
		dropped = 1'b0;
		while (held > 0) begin
			// a timestamp older than the entry counts as age zero
			age = (t >= ring_time[oldest_slot]) ? t - ring_time[oldest_slot] : '0;
			if (age > TIME_W'(win))
				retire_oldest();
			else
				break;
		end
		if (held >= WINDOW_DEPTH) begin
			retire_oldest();
			dropped = 1'b1;
		end
		slot = oldest_slot + held;
		if (slot >= WINDOW_DEPTH)
			slot -= WINDOW_DEPTH;
		ring_time[slot] = t;
		ring_vol[slot] = v;
		held++;
		total = total + widen_vol(v);
		res.total = total;
		res.held = HELD_W'(held);
		res.ovf = dropped;
		predicted_results = {predicted_results, res};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win = WINDOW_RESET;
			oldest_slot = 0;
			held = 0;
			total = '0;
			predicted_results.delete();
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("result word with nothing pending", window_total, 0);
				end else begin
					want = predicted_results.pop_front();
					if (window_total !== want.total)
						report_mismatch("window_total", window_total, want.total);
					if (entries_held !== want.held)
						report_mismatch("entries_held", entries_held, want.held);
					if (overflow !== want.ovf)
						report_mismatch("overflow", overflow, want.ovf);
				end
			end
			if (cfg_valid && cfg_ready)
				win = cfg_data;
			if (in_valid && !in_stall)
				apply_event(event_time_ns, volume);
			outstanding = predicted_results.size();
		end
	end

endmodule

/* test/time_window_volume_sum_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_window_volume_sum_test
// Drives the window sum block with directed and random event words.
// A short directed run covers window boundaries, backwards timestamps and
// extreme volumes and times; random runs then sweep several window settings,
// from zero to the largest, under three sender and receiver idling mixes.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module time_window_volume_sum_test;
	import twvs_pkg::*;

	localparam int DEPTH = 64;
	localparam int ITEMS_PER_WINDOW = 42;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [WIN_W-1:0] WIN_MAX = '1;
	localparam logic signed [VOL_W-1:0] VOL_MAX = {1'b0, {(VOL_W-1){1'b1}}};
	localparam logic signed [VOL_W-1:0] VOL_MIN = {1'b1, {(VOL_W-1){1'b0}}};

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [WIN_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_stall;
	logic [TIME_W-1:0]       event_time_ns;
	logic signed [VOL_W-1:0] volume;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [SUM_W-1:0] window_total;
	logic [HELD_W-1:0]       entries_held;
	logic                    overflow;

	int mismatches;
	int outstanding;
	int sender_idle_pct;
	int recv_stall_pct;

	logic [TIME_W-1:0] now;
	logic [WIN_W-1:0]  win_now;
	logic [TIME_W-1:0] sent_times [$];
	logic [WIN_W-1:0]  window_plan [12];

	time_window_volume_sum #(
		.WINDOW_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.event_time_ns(event_time_ns),
		.volume(volume),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.window_total(window_total),
		.entries_held(entries_held),
		.overflow(overflow)
	);

	time_window_volume_sum_check #(
		.WINDOW_DEPTH(DEPTH)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.event_time_ns(event_time_ns),
		.volume(volume),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.window_total(window_total),
		.entries_held(entries_held),
		.overflow(overflow),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_event(input logic [TIME_W-1:0] t, input logic signed [VOL_W-1:0] v);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		event_time_ns <= t;
		volume <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		sent_times = {sent_times, t};
		if (sent_times.size() > DEPTH)
			void'(sent_times.pop_front());
	endtask

	// only written once every pending result word has come back
	task automatic write_window(input logic [WIN_W-1:0] w);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		win_now = w;
	endtask

	task automatic send_random_event();
		int                      sel;
		logic [TIME_W-1:0]       t;
		logic [TIME_W-1:0]       delta;
		logic signed [VOL_W-1:0] v;
		sel = $urandom_range(99);
		if (sel < 70) begin
			// ordinary forward step, scaled to the window so entries pile up and age out
			case ($urandom_range(3))
				0: delta = '0;
				1: delta = TIME_W'($urandom_range(0, 3));
				2: delta = TIME_W'((win_now / 64) * $urandom_range(0, 2));
				default: delta = TIME_W'((win_now / 16) * $urandom_range(0, 3)
					+ $urandom_range(0, 7));
			endcase
			now = now + delta;
			t = now;
		end else if (sel < 80 && sent_times.size() > 0) begin
			// land on or just beside the age boundary of an earlier word
			t = sent_times[$urandom_range(0, sent_times.size() - 1)] + TIME_W'(win_now)
				+ TIME_W'($urandom_range(0, 2)) - TIME_W'(1);
			if (t > now)
				now = t;
		end else if (sel < 90) begin
			t = now - TIME_W'($urandom_range(0, 5000));
		end else begin
			now = TIME_W'({$urandom, $urandom});
			t = now;
		end
		if ($urandom_range(9) == 0)
			v = $urandom_range(1) ? VOL_MAX : VOL_MIN;
		else
			v = $urandom;
		send_event(t, v);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		event_time_ns = '0;
		volume = '0;
		out_stall = 1'b0;
		sender_idle_pct = 23;
		recv_stall_pct = 65;
		now = '0;
		win_now = WINDOW_RESET;
		window_plan[0] = '0;
		window_plan[1] = WIN_MAX;
		window_plan[2] = 40'd1000;
		window_plan[3] = WIN_W'({$urandom_range(255), $urandom});
		window_plan[4] = WINDOW_RESET;
		window_plan[5] = 40'd1;
		window_plan[6] = WIN_W'({$urandom_range(255), $urandom});
		window_plan[7] = 40'd64;
		window_plan[8] = {8'd0, $urandom};
		window_plan[9] = WIN_MAX;
		window_plan[10] = '0;
		window_plan[11] = 40'd100000;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset window: boundary age equal to the window stays, one past leaves
		send_event('0, '0);
		send_event(63'd1000, VOL_MAX);
		send_event(63'd3000000000, VOL_MIN);
		send_event(63'd3000000001, -32'sd1);
		// timestamp going backwards counts as age zero
		send_event(63'd5, 32'sd1);
		// eviction stops at the first live entry, the older backwards one stays behind it
		send_event(63'd3000001001, 32'sd12345);
		send_event(TIME_MAX, VOL_MAX);
		send_event(TIME_MAX, VOL_MAX);

		write_window('0);
		send_event(63'd100, VOL_MIN);
		send_event(63'd100, VOL_MIN);
		send_event(TIME_MAX, VOL_MIN);
		send_event(TIME_MAX, 32'sd7);

		write_window(WIN_MAX);
		send_event('0, VOL_MAX);
		send_event({23'd0, WIN_MAX}, VOL_MIN);
		send_event({23'd0, WIN_MAX} + 63'd1, -32'sd2);
		send_event({23'd0, WIN_MAX} + 63'd2, VOL_MAX);
		now = {23'd0, WIN_MAX} + 63'd2;

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					sender_idle_pct = 23;
					recv_stall_pct = 65;
				end
				1: begin
					sender_idle_pct = 65;
					recv_stall_pct = 23;
				end
				default: begin
					sender_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int k = 0; k < 4; k++) begin
				write_window(window_plan[mode * 4 + k]);
				repeat (ITEMS_PER_WINDOW)
					send_random_event();
			end
		end

		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
